[sv/bwmf_pkg.sv]
// Shared types and constants of the bootloader write-memory framer.
`default_nettype none

package bwmf_pkg;

   localparam int SIZE_W          = 17;
   localparam int ADDR_W          = 32;
   localparam int MAX_WORDS       = 6;
   localparam int WIDX_W          = $clog2(MAX_WORDS);
   localparam int IMAGE_MAX       = 65536;
   localparam int CHUNK_MAX_DEF   = 256;
   localparam int QUEUE_DEPTH_DEF = 2;
   localparam int CSR_ADDR_W      = 3;

   localparam logic [7:0] WRITE_CMD = 8'h31;
   localparam logic [7:0] ACK_BYTE  = 8'h79;
   localparam logic [7:0] NACK_BYTE = 8'h1F;
   localparam logic [7:0] PAD_BYTE  = 8'hFF;

   localparam logic [ADDR_W-1:0] BASE_RESET = 32'h0800_0000;
   localparam logic [SIZE_W-1:0] SIZE_RESET = 17'd1;

   // register index, taken from paddr[2]
   localparam logic REG_BASE_ADDRESS = 1'b0;
   localparam logic REG_IMAGE_LENGTH = 1'b1;

   localparam logic [1:0] ACT_IMAGE   = 2'd0;
   localparam logic [1:0] ACT_REPLY   = 2'd1;
   localparam logic [1:0] ACT_TIMEOUT = 2'd2;

   typedef enum logic [3:0] {
      ST_SENDING      = 4'd0,
      ST_WANT_DATA    = 4'd1,
      ST_AWAIT_REPLY  = 4'd2,
      ST_CHUNK_ACKED  = 4'd3,
      ST_IMAGE_DONE   = 4'd4,
      ST_NACK         = 4'd5,
      ST_BAD_REPLY    = 4'd6,
      ST_TIMEOUT      = 4'd7,
      ST_OUT_OF_ORDER = 4'd8
   } status_type;

   typedef struct packed {
      logic [1:0] action;
      logic [7:0] image_byte;
      logic [7:0] reply_byte;
   } req_type;

   typedef struct packed {
      logic [7:0] tx_byte;
      logic       tx_valid;
      logic       last_of_run;
      status_type status;
   } rsp_type;

   // One job per accepted word: the bytes to send, index of the final word
   // and what the final word carries. Earlier words are valid, status 0.
   typedef struct packed {
      logic [MAX_WORDS-1:0][7:0] bytes;
      logic [WIDX_W-1:0]         last_idx;
      logic                      fin_valid;
      status_type                fin_status;
   } job_type;

endpackage

`default_nettype wire

[sv/bwmf_front.sv]
// Front end: classifies input words, tracks the exchange and builds jobs.
`default_nettype none

module bwmf_front
   import bwmf_pkg::*;
#(
   parameter int CHUNK_MAX = CHUNK_MAX_DEF
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              accept,
   input  wire req_type           req_item,
   input  wire logic [ADDR_W-1:0] base_address,
   input  wire logic [SIZE_W-1:0] image_length,
   output job_type                job
);

   localparam int CLEN_W = $clog2(CHUNK_MAX + 1);

   typedef enum logic [2:0] {
      PH_IDLE, PH_CMD, PH_ADDR, PH_DATA, PH_SUM, PH_DONE, PH_FAIL
   } phase_type;

   phase_type         phase_ff, phase_in;
   logic [SIZE_W-1:0] offset_ff, offset_in;
   logic [CLEN_W-1:0] len_ff, len_in;
   logic [CLEN_W-1:0] left_ff, left_in;
   logic [7:0]        xor_ff, xor_in;
   logic [7:0]        held_ff, held_in;

   logic [SIZE_W-1:0] eff_size;
   logic [SIZE_W-1:0] remain;
   logic [CLEN_W-1:0] real_len;
   logic [CLEN_W:0]   padded;
   logic [7:0]        len_byte;
   logic [1:0]        pads;
   logic [7:0]        pad_xor;
   logic [ADDR_W-1:0] addr;
   logic [SIZE_W-1:0] offset_next;
   logic              awaiting;
   logic [7:0]        xor_n;
   logic [7:0]        sum;
   logic [CLEN_W-1:0] left_dec;
   logic [WIDX_W-1:0] sum_idx;

   always_comb begin
      eff_size = (32'(image_length) > IMAGE_MAX) ? SIZE_W'(IMAGE_MAX) : image_length;
      remain   = eff_size - offset_ff;
      real_len = (remain > SIZE_W'(CHUNK_MAX)) ? CLEN_W'(CHUNK_MAX) : CLEN_W'(remain);
      padded   = ({1'b0, len_ff} + (CLEN_W+1)'(3)) & ~(CLEN_W+1)'(3);
      len_byte = 8'(padded - (CLEN_W+1)'(1));
      pads     = 2'(2'd0 - len_ff[1:0]);
      pad_xor  = pads[0] ? PAD_BYTE : 8'h00;
      addr     = base_address + ADDR_W'(offset_ff);
      offset_next = offset_ff + SIZE_W'(len_ff);
      awaiting = phase_ff inside {PH_CMD, PH_ADDR, PH_SUM};
   end

   always_comb begin
      phase_in  = phase_ff;
      offset_in = offset_ff;
      len_in    = len_ff;
      left_in   = left_ff;
      xor_in    = xor_ff;
      held_in   = held_ff;
      xor_n     = 8'h00;
      sum       = 8'h00;
      left_dec  = '0;
      sum_idx   = '0;

      job.bytes      = {MAX_WORDS{PAD_BYTE}};
      job.bytes[0]   = 8'h00;
      job.last_idx   = '0;
      job.fin_valid  = 1'b0;
      job.fin_status = ST_OUT_OF_ORDER;

      if (req_item.action == ACT_IMAGE && phase_ff == PH_IDLE && offset_ff < eff_size) begin
         len_in         = real_len;
         held_in        = req_item.image_byte;
         job.bytes[0]   = WRITE_CMD;
         job.bytes[1]   = ~WRITE_CMD;
         job.last_idx   = WIDX_W'(1);
         job.fin_valid  = 1'b1;
         job.fin_status = ST_AWAIT_REPLY;
         phase_in       = PH_CMD;
      end else if (req_item.action == ACT_IMAGE && phase_ff == PH_DATA) begin
         xor_n          = xor_ff ^ req_item.image_byte;
         left_dec       = (left_ff != '0) ? left_ff - CLEN_W'(1) : left_ff;
         left_in        = left_dec;
         xor_in         = xor_n;
         job.bytes[0]   = req_item.image_byte;
         job.fin_valid  = 1'b1;
         if (left_dec == '0) begin
            // chunk ends here: pad, then checksum
            sum            = xor_n ^ pad_xor;
            sum_idx        = WIDX_W'(1) + WIDX_W'(pads);
            job.bytes[sum_idx] = sum;
            job.last_idx   = sum_idx;
            job.fin_status = ST_AWAIT_REPLY;
            xor_in         = sum;
            phase_in       = PH_SUM;
         end else begin
            job.fin_status = ST_WANT_DATA;
         end
      end else if (req_item.action == ACT_REPLY && awaiting &&
                   req_item.reply_byte != ACK_BYTE) begin
         job.fin_status = (req_item.reply_byte == NACK_BYTE) ? ST_NACK : ST_BAD_REPLY;
         phase_in       = PH_FAIL;
      end else if (req_item.action == ACT_TIMEOUT && awaiting) begin
         job.fin_status = ST_TIMEOUT;
         phase_in       = PH_FAIL;
      end else if (req_item.action == ACT_REPLY && phase_ff == PH_CMD) begin
         job.bytes[0]   = addr[31:24];
         job.bytes[1]   = addr[23:16];
         job.bytes[2]   = addr[15:8];
         job.bytes[3]   = addr[7:0];
         job.bytes[4]   = addr[31:24] ^ addr[23:16] ^ addr[15:8] ^ addr[7:0];
         job.last_idx   = WIDX_W'(4);
         job.fin_valid  = 1'b1;
         job.fin_status = ST_AWAIT_REPLY;
         phase_in       = PH_ADDR;
      end else if (req_item.action == ACT_REPLY && phase_ff == PH_ADDR) begin
         xor_n          = len_byte ^ held_ff;
         left_dec       = (len_ff != '0) ? len_ff - CLEN_W'(1) : '0;
         left_in        = left_dec;
         xor_in         = xor_n;
         job.bytes[0]   = len_byte;
         job.bytes[1]   = held_ff;
         job.fin_valid  = 1'b1;
         if (left_dec == '0) begin
            sum            = xor_n ^ pad_xor;
            sum_idx        = WIDX_W'(2) + WIDX_W'(pads);
            job.bytes[sum_idx] = sum;
            job.last_idx   = sum_idx;
            job.fin_status = ST_AWAIT_REPLY;
            xor_in         = sum;
            phase_in       = PH_SUM;
         end else begin
            job.last_idx   = WIDX_W'(1);
            job.fin_status = ST_WANT_DATA;
            phase_in       = PH_DATA;
         end
      end else if (req_item.action == ACT_REPLY && phase_ff == PH_SUM) begin
         offset_in = offset_next;
         if (offset_next >= eff_size) begin
            job.fin_status = ST_IMAGE_DONE;
            phase_in       = PH_DONE;
         end else begin
            job.fin_status = ST_CHUNK_ACKED;
            phase_in       = PH_IDLE;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         held_ff <= held_in;
      end
      if (reset) begin
         phase_ff  <= PH_IDLE;
         offset_ff <= '0;
         len_ff    <= '0;
         left_ff   <= '0;
         xor_ff    <= '0;
      end else if (accept) begin
         phase_ff  <= phase_in;
         offset_ff <= offset_in;
         len_ff    <= len_in;
         left_ff   <= left_in;
         xor_ff    <= xor_in;
      end
   end

endmodule

`default_nettype wire

[sv/bwmf_queue.sv]
// Short job queue between front and back end.
`default_nettype none

module bwmf_queue
   import bwmf_pkg::*;
#(
   parameter int DEPTH = QUEUE_DEPTH_DEF
) (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    push,
   input  wire job_type push_job,
   output logic         full,
   input  wire logic    pop,
   output logic         nonempty,
   output job_type      head_job
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   job_type           slot_ff [DEPTH];
   logic [PTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic              do_push;
   logic              do_pop;

   always_comb begin
      full     = (count_ff == CNT_W'(DEPTH));
      nonempty = (count_ff != '0);
      head_job = slot_ff[rd_ptr_ff];
      do_push  = push && !full;
      do_pop   = pop && nonempty;
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      count_in = count_ff + CNT_W'(do_push) - CNT_W'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_job;
      end
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

`default_nettype wire

[sv/bwmf_back.sv]
// Back end: expands each job into result words, one word per cycle while rsp_ready does not stall it.
`default_nettype none

module bwmf_back
   import bwmf_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    job_valid,
   input  wire job_type job,
   output logic         job_pop,
   output logic         rsp_valid,
   input  wire logic    rsp_ready,
   output rsp_type      rsp_item
);

   logic [WIDX_W-1:0] idx_ff, idx_in;
   logic              rsp_valid_ff, rsp_valid_in;
   rsp_type           rsp_item_ff, rsp_item_in;
   logic              take;
   logic              is_last;

   always_comb begin
      take    = job_valid && (!rsp_valid_ff || rsp_ready);
      is_last = (idx_ff == job.last_idx);
      job_pop = take && is_last;

      rsp_item_in.tx_byte     = job.bytes[idx_ff];
      rsp_item_in.tx_valid    = is_last ? job.fin_valid : 1'b1;
      rsp_item_in.last_of_run = is_last;
      rsp_item_in.status      = is_last ? job.fin_status : ST_SENDING;

      idx_in = idx_ff;
      if (take) begin
         idx_in = is_last ? '0 : idx_ff + WIDX_W'(1);
      end

      rsp_valid_in = rsp_valid_ff;
      if (take) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         rsp_item_ff <= rsp_item_in;
      end
      if (reset) begin
         idx_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         idx_ff       <= idx_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_item_ff;

endmodule

`default_nettype wire

[sv/bootloader_write_memory_framer_unit.sv]
// Top level of the bootloader write-memory framer: CSRs, front, queue, back.
`default_nettype none

// Frames an image into serial bootloader write-memory exchanges. Each input
// word (image byte, reply byte or timeout) is classified by the front end in
// the cycle it is accepted and turned into one job of 1 to 6 result words in
// a job queue of QUEUE_DEPTH entries. The back end drains one result word per
// cycle through its output register unless rsp_ready stalls it. Per input
// word: 1 word for data bytes and replies that end a run, 2 for a command,
// 5 for the address frame and up to 5 or 6 for a chunk's tail. When empty,
// an accepted word passes the queue, then the output register (rsp_valid).
// req_ready drops only while the queue is full. Configuration writes take
// effect at once and are meant for idle periods; a new image length applies
// from the next chunk. No clearing pass is needed after reset.
module bootloader_write_memory_framer_unit
   import bwmf_pkg::*;
#(
   parameter int CHUNK_MAX   = CHUNK_MAX_DEF,
   parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_valid,
   output logic                       req_ready,
   input  wire req_type               req_item,
   output logic                       rsp_valid,
   input  wire logic                  rsp_ready,
   output rsp_type                    rsp_item,
   input  wire logic                  csr_psel,
   input  wire logic                  csr_penable,
   input  wire logic                  csr_pwrite,
   input  wire logic [CSR_ADDR_W-1:0] csr_paddr,
   input  wire logic [31:0]           csr_pwdata,
   output logic [31:0]                csr_prdata,
   output logic                       csr_pready
);

   logic [ADDR_W-1:0] base_address_ff;
   logic [SIZE_W-1:0] image_length_ff;
   logic              csr_write;
   logic              accept;
   logic              queue_full;
   logic              queue_nonempty;
   logic              queue_pop;
   job_type           front_job;
   job_type           head_job;

   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite;

   always_comb begin
      case (csr_paddr[2])
         REG_BASE_ADDRESS: csr_prdata = base_address_ff;
         REG_IMAGE_LENGTH: csr_prdata = {{(32 - SIZE_W){1'b0}}, image_length_ff};
         default:          csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         base_address_ff <= BASE_RESET;
         image_length_ff <= SIZE_RESET;
      end else if (csr_write) begin
         case (csr_paddr[2])
            REG_BASE_ADDRESS: base_address_ff <= csr_pwdata;
            REG_IMAGE_LENGTH: image_length_ff <= csr_pwdata[SIZE_W-1:0];
            default:          ;
         endcase
      end
   end

   assign req_ready = !queue_full;
   assign accept    = req_valid && req_ready;

   bwmf_front #(
      .CHUNK_MAX (CHUNK_MAX)
   ) u_front (
      .clock        (clock),
      .reset        (reset),
      .accept       (accept),
      .req_item     (req_item),
      .base_address (base_address_ff),
      .image_length (image_length_ff),
      .job          (front_job)
   );

   bwmf_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (accept),
      .push_job (front_job),
      .full     (queue_full),
      .pop      (queue_pop),
      .nonempty (queue_nonempty),
      .head_job (head_job)
   );

   bwmf_back u_back (
      .clock     (clock),
      .reset     (reset),
      .job_valid (queue_nonempty),
      .job       (head_job),
      .job_pop   (queue_pop),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_item  (rsp_item)
   );

endmodule

`default_nettype wire

[sv/bwmf_checker.sv]
// Port-level checks of the framer, bound to the top level.
`default_nettype none

module bwmf_checker
   import bwmf_pkg::*;
(
   input wire logic    clock,
   input wire logic    reset,
   input wire logic    rsp_valid,
   input wire logic    rsp_ready,
   input wire rsp_type rsp_item
);

   // a stalled result word holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_item))
      else $error("result word changed while stalled");

   // only the final word of a run carries a nonzero status
   a_last_status: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_item.last_of_run == (rsp_item.status != ST_SENDING)))
      else $error("last_of_run and status disagree");

   // a word with nothing to send ends its run and carries zero
   a_idle_word: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_item.tx_valid |-> rsp_item.last_of_run && rsp_item.tx_byte == 8'h00)
      else $error("empty word not final or not zero");

   // a run that waits for a reply ends on a transmitted byte
   a_await_sends: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_item.status == ST_AWAIT_REPLY || rsp_item.status == ST_WANT_DATA)
      |-> rsp_item.tx_valid)
      else $error("await or want status without a byte");

endmodule

bind bootloader_write_memory_framer_unit bwmf_checker u_bwmf_checker (
   .clock     (clock),
   .reset     (reset),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp_item  (rsp_item)
);

`default_nettype wire
